// ===== sv/text_stream_display_filter_core_macros.svh =====
// Assertion macros shared by the text stream display filter.
`ifndef TEXT_STREAM_DISPLAY_FILTER_CORE_MACROS_SVH
`define TEXT_STREAM_DISPLAY_FILTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define TSDF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("tsdf assertion failed");
`define TSDF_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("tsdf forbidden condition seen");
`else
`define TSDF_ASSERT(lbl, clk, rst_n, prop)
`define TSDF_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// ===== sv/tsdf_pkg.sv =====
// Shared types, constants and functions of the text stream display filter.
package tsdf_pkg;

  localparam int NUMBER_DIGITS_DEF   = 10;
  localparam int MIN_FIELD_WIDTH_DEF = 6;
  localparam int FIFO_DEPTH          = 2;
  localparam int LIMIT_DIGITS        = 10;
  localparam int ADDR_W              = 5;

  localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd0;
  localparam logic [2:0] REG_NUMBER_NONBLANK  = 3'd1;
  localparam logic [2:0] REG_NUMBER_ALL       = 3'd2;
  localparam logic [2:0] REG_SHOW_ENDS        = 3'd3;
  localparam logic [2:0] REG_SHOW_TABS        = 3'd4;
  localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd5;

  localparam logic [7:0] CH_NL       = 8'd10;
  localparam logic [7:0] CH_TAB      = 8'd9;
  localparam logic [7:0] CH_DEL      = 8'd127;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_DOLLAR   = 8'h24;
  localparam logic [7:0] CH_CARET    = 8'h5e;
  localparam logic [7:0] CH_I        = 8'h49;
  localparam logic [7:0] CARET_SHIFT = 8'd64;
  localparam logic [7:0] CTRL_LOW_END  = 8'd8;
  localparam logic [7:0] CTRL_HIGH_BEG = 8'd11;
  localparam logic [7:0] CTRL_HIGH_END = 8'd31;
  localparam logic [3:0] BCD_NINE    = 4'd9;

  typedef struct packed {
    logic squeeze_blank;
    logic number_nonblank;
    logic number_all;
    logic show_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       caret;
    logic       dollar;
    logic       number;
  } ent_t;

  typedef struct packed {
    logic busy;
    logic step;
  } back_stat_t;

  // Digits of 2147483647, least significant first.
  function automatic logic [3:0] limit_digit(input int idx);
    logic [3:0] d;
    case (idx)
      0: d = 4'd7;
      1: d = 4'd4;
      2: d = 4'd6;
      3: d = 4'd3;
      4: d = 4'd8;
      5: d = 4'd4;
      6: d = 4'd7;
      7: d = 4'd4;
      8: d = 4'd1;
      9: d = 4'd2;
      default: d = 4'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== sv/tsdf_front.sv =====
// Front end: accepts input beats, squeezes, counts lines and classifies bytes.
module tsdf_front #(
  parameter int NUMBER_DIGITS = tsdf_pkg::NUMBER_DIGITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tsdf_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   in_byte_i,
  input  logic                         file_start_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output tsdf_pkg::ent_t               push_ent_o,
  output logic [NUMBER_DIGITS-1:0][3:0] push_digits_o
);
  import tsdf_pkg::*;

  localparam bit HAS_MAX = (NUMBER_DIGITS >= LIMIT_DIGITS);

  logic [7:0]                    prev_q, prev_d, prev;
  logic [1:0]                    br_q, br_d, br;
  logic [NUMBER_DIGITS-1:0][3:0] dig_q, dig_d, dig, dig_inc, dig_n;
  logic                          sq_hit, drop, num_line, do_num;
  logic                          all_nine, at_max, carry, accept;
  logic                          tab_hit, ctrl_hit, del_hit;
  logic [7:0]                    c_tab, c_fin;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;

  always_comb begin
    prev = file_start_i ? CH_NL : prev_q;
    br   = file_start_i ? 2'd0 : br_q;
    dig  = file_start_i ? '0 : dig_q;

    sq_hit = cfg_i.squeeze_blank && (in_byte_i == CH_NL) && (prev == CH_NL);
    br_d   = sq_hit ? ((br == 2'd2) ? br : br + 2'd1) : 2'd0;
    drop   = sq_hit && (br_d == 2'd2);

    num_line = cfg_i.number_nonblank ? (in_byte_i != CH_NL) : cfg_i.number_all;
    do_num   = (prev == CH_NL) && num_line;

    all_nine = 1'b1;
    at_max   = HAS_MAX;
    carry    = 1'b1;
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (dig[i] != BCD_NINE) all_nine = 1'b0;
      if (dig[i] != limit_digit(i)) at_max = 1'b0;
      dig_inc[i] = carry ? ((dig[i] >= BCD_NINE) ? 4'd0 : dig[i] + 4'd1) : dig[i];
      carry      = carry && (dig[i] >= BCD_NINE);
    end
    dig_n = (do_num && !(all_nine || at_max)) ? dig_inc : dig;

    tab_hit  = cfg_i.show_tabs && (in_byte_i == CH_TAB);
    c_tab    = tab_hit ? CH_I : in_byte_i;
    ctrl_hit = cfg_i.show_nonprinting && ((c_tab <= CTRL_LOW_END) ||
               ((c_tab >= CTRL_HIGH_BEG) && (c_tab <= CTRL_HIGH_END)));
    del_hit  = cfg_i.show_nonprinting && (c_tab == CH_DEL);
    c_fin    = ctrl_hit ? c_tab + CARET_SHIFT : (del_hit ? c_tab - CARET_SHIFT : c_tab);

    prev_d = accept ? (drop ? prev : c_fin) : prev_q;
    dig_d  = accept ? (drop ? dig : dig_n) : dig_q;
    if (!accept) br_d = br_q;
  end

  assign push_valid_o           = in_valid_i && !drop;
  assign push_ent_o.char_out    = c_fin;
  assign push_ent_o.caret       = tab_hit || ctrl_hit || del_hit;
  assign push_ent_o.dollar      = cfg_i.show_ends && (in_byte_i == CH_NL);
  assign push_ent_o.number      = do_num;
  assign push_digits_o          = dig_n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= CH_NL;
      br_q   <= 2'd0;
      dig_q  <= '0;
    end else begin
      prev_q <= prev_d;
      br_q   <= br_d;
      dig_q  <= dig_d;
    end
  end

endmodule

// ===== sv/tsdf_fifo.sv =====
// Small register queue between the front and back ends.
module tsdf_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = tsdf_pkg::FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_valid_i,
  output logic             wr_ready_o,
  input  logic [WIDTH-1:0] wr_data_i,
  output logic             rd_valid_o,
  input  logic             rd_ready_i,
  output logic [WIDTH-1:0] rd_data_o
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign wr_ready_o = (cnt_q != CNT_FULL);
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  always_comb begin
    wptr_d = wr_en ? ((wptr_q == PTR_LAST) ? '0 : wptr_q + PW'(1)) : wptr_q;
    rptr_d = rd_en ? ((rptr_q == PTR_LAST) ? '0 : rptr_q + PW'(1)) : rptr_q;
    cnt_d  = cnt_q + CW'(wr_en) - CW'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= wr_data_i;
  end

endmodule

// ===== sv/tsdf_back.sv =====
// Back end: expands each queued entry into output bytes, one per cycle unless the output stalls.
module tsdf_back #(
  parameter int NUMBER_DIGITS   = tsdf_pkg::NUMBER_DIGITS_DEF,
  parameter int MIN_FIELD_WIDTH = tsdf_pkg::MIN_FIELD_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  tsdf_pkg::ent_t                in_ent_i,
  input  logic [NUMBER_DIGITS-1:0][3:0] in_digits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    out_byte_o,
  output logic                          out_last_o,
  output tsdf_pkg::back_stat_t          stat_o
);
  import tsdf_pkg::*;

  localparam int CW = $clog2(NUMBER_DIGITS + 1);
  localparam int IW = $clog2(NUMBER_DIGITS);
  localparam logic [CW-1:0] MIN_W = CW'((MIN_FIELD_WIDTH > NUMBER_DIGITS) ?
                                        NUMBER_DIGITS : MIN_FIELD_WIDTH);

  localparam logic [2:0] PH_PAD   = 3'd0;
  localparam logic [2:0] PH_DIG   = 3'd1;
  localparam logic [2:0] PH_TAB   = 3'd2;
  localparam logic [2:0] PH_DOL   = 3'd3;
  localparam logic [2:0] PH_CARET = 3'd4;
  localparam logic [2:0] PH_CHAR  = 3'd5;

  logic                          busy_q, busy_d;
  logic [2:0]                    ph_q, ph_d;
  logic [CW-1:0]                 cnt_q, cnt_d, sig_q, sig_d, sig, width;
  ent_t                          ent_q, ent_d;
  logic [NUMBER_DIGITS-1:0][3:0] dig_q, dig_d;
  logic                          ov_q, ov_d, olast_q, olast_d;
  logic [7:0]                    obyte_q, obyte_d;
  logic                          load, step;
  logic [2:0]                    ph_tail;

  assign in_ready_o = !busy_q;
  assign load       = in_valid_i && !busy_q;
  assign step       = busy_q && (!ov_q || out_ready_i);

  always_comb begin
    sig = CW'(1);
    for (int i = 0; i < NUMBER_DIGITS; i++) begin
      if (in_digits_i[i] != 4'd0) sig = CW'(i + 1);
    end
    width = (sig > MIN_W) ? sig : MIN_W;
  end

  always_comb begin
    busy_d  = busy_q;
    ph_d    = ph_q;
    cnt_d   = cnt_q;
    sig_d   = sig_q;
    ent_d   = ent_q;
    dig_d   = dig_q;
    ov_d    = ov_q && !out_ready_i;
    obyte_d = obyte_q;
    olast_d = olast_q;
    ph_tail = ent_q.dollar ? PH_DOL : (ent_q.caret ? PH_CARET : PH_CHAR);

    if (load) begin
      busy_d = 1'b1;
      ent_d  = in_ent_i;
      dig_d  = in_digits_i;
      sig_d  = sig;
      if (in_ent_i.number) begin
        if (width > sig) begin
          ph_d  = PH_PAD;
          cnt_d = width - sig;
        end else begin
          ph_d  = PH_DIG;
          cnt_d = sig - CW'(1);
        end
      end else if (in_ent_i.dollar) begin
        ph_d = PH_DOL;
      end else if (in_ent_i.caret) begin
        ph_d = PH_CARET;
      end else begin
        ph_d = PH_CHAR;
      end
    end

    if (step) begin
      ov_d    = 1'b1;
      olast_d = 1'b0;
      case (ph_q)
        PH_PAD: begin
          obyte_d = CH_SPACE;
          if (cnt_q == CW'(1)) begin
            ph_d  = PH_DIG;
            cnt_d = sig_q - CW'(1);
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end
        PH_DIG: begin
          obyte_d = CH_ZERO + {4'd0, dig_q[cnt_q[IW-1:0]]};
          if (cnt_q == '0) begin
            ph_d = PH_TAB;
          end else begin
            cnt_d = cnt_q - CW'(1);
          end
        end
        PH_TAB: begin
          obyte_d = CH_TAB;
          ph_d    = ph_tail;
        end
        PH_DOL: begin
          obyte_d = CH_DOLLAR;
          ph_d    = ent_q.caret ? PH_CARET : PH_CHAR;
        end
        PH_CARET: begin
          obyte_d = CH_CARET;
          ph_d    = PH_CHAR;
        end
        default: begin
          obyte_d = ent_q.char_out;
          olast_d = 1'b1;
          busy_d  = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PH_CHAR;
      ov_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      ov_q   <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q   <= cnt_d;
    sig_q   <= sig_d;
    ent_q   <= ent_d;
    dig_q   <= dig_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o = ov_q;
  assign out_byte_o  = obyte_q;
  assign out_last_o  = olast_q;
  assign stat_o.busy = busy_q;
  assign stat_o.step = step;

endmodule

// ===== sv/text_stream_display_filter_core.sv =====
// Top level of the text stream display filter with its register port.
//
// Raw text enters one byte per beat on the s_axis channel; tuser marks the
// first byte of a new file, which clears the line count and line state.
// Every input byte yields zero to NUMBER_DIGITS+3 output beats on m_axis,
// and tlast marks the final beat caused by that byte. A squeezed empty line
// gives no beat at all.
// The front end takes a byte every cycle while its two-entry queue has room.
// The back end loads an entry only while idle, then gives its output bytes
// one per cycle while m_axis is not stalled; a numbered line start first
// gives the padded number field and a tab. An accepted byte passes through
// the queue and the entry registers before the output register shows it.
// A stall on m_axis holds the output register, the back end waits, the queue
// fills and s_axis tready drops; no beat is lost.
// Reset clears the options, the line count and the queue. The options are
// set through the register port at byte addresses 0 to 20 and should only
// change while the block is idle.
module text_stream_display_filter_core #(
  parameter int NUMBER_DIGITS   = tsdf_pkg::NUMBER_DIGITS_DEF,
  parameter int MIN_FIELD_WIDTH = tsdf_pkg::MIN_FIELD_WIDTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,  // in_byte
  input  logic                        s_axis_tuser,  // file_start
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,  // out_byte
  output logic                        m_axis_tlast,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [tsdf_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tsdf_pkg::*;

  `include "text_stream_display_filter_core_macros.svh"

  localparam int QW = $bits(ent_t) + 4 * NUMBER_DIGITS;

  cfg_t                          cfg_q, cfg_d;
  logic                          wr_en;
  logic                          push_valid, push_ready, pop_valid, pop_ready;
  ent_t                          push_ent, pop_ent;
  logic [NUMBER_DIGITS-1:0][3:0] push_digits, pop_digits;
  back_stat_t                    back_stat;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[ADDR_W-1:2])
        REG_SQUEEZE_BLANK:    cfg_d.squeeze_blank    = pwdata[0];
        REG_NUMBER_NONBLANK:  cfg_d.number_nonblank  = pwdata[0];
        REG_NUMBER_ALL:       cfg_d.number_all       = pwdata[0];
        REG_SHOW_ENDS:        cfg_d.show_ends        = pwdata[0];
        REG_SHOW_TABS:        cfg_d.show_tabs        = pwdata[0];
        REG_SHOW_NONPRINTING: cfg_d.show_nonprinting = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (paddr[ADDR_W-1:2])
      REG_SQUEEZE_BLANK:    prdata[0] = cfg_q.squeeze_blank;
      REG_NUMBER_NONBLANK:  prdata[0] = cfg_q.number_nonblank;
      REG_NUMBER_ALL:       prdata[0] = cfg_q.number_all;
      REG_SHOW_ENDS:        prdata[0] = cfg_q.show_ends;
      REG_SHOW_TABS:        prdata[0] = cfg_q.show_tabs;
      REG_SHOW_NONPRINTING: prdata[0] = cfg_q.show_nonprinting;
      default:              prdata    = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tsdf_front #(
    .NUMBER_DIGITS(NUMBER_DIGITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_byte_i    (s_axis_tdata),
    .file_start_i (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_ent_o   (push_ent),
    .push_digits_o(push_digits)
  );

  tsdf_fifo #(
    .WIDTH(QW),
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_valid_i(push_valid),
    .wr_ready_o(push_ready),
    .wr_data_i ({push_digits, push_ent}),
    .rd_valid_o(pop_valid),
    .rd_ready_i(pop_ready),
    .rd_data_o ({pop_digits, pop_ent})
  );

  tsdf_back #(
    .NUMBER_DIGITS  (NUMBER_DIGITS),
    .MIN_FIELD_WIDTH(MIN_FIELD_WIDTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pop_valid),
    .in_ready_o (pop_ready),
    .in_ent_i   (pop_ent),
    .in_digits_i(pop_digits),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_byte_o (m_axis_tdata),
    .out_last_o (m_axis_tlast),
    .stat_o     (back_stat)
  );

  `TSDF_ASSERT(a_pop_loads_back, clk_i, rst_ni, (pop_valid && pop_ready) |=> back_stat.busy)
  `TSDF_ASSERT(a_busy_emits, clk_i, rst_ni, (back_stat.busy && !m_axis_tvalid) |-> back_stat.step)
  `TSDF_ASSERT(a_step_shows_beat, clk_i, rst_ni, back_stat.step |=> m_axis_tvalid)
  `TSDF_NEVER(a_ready_tracks_queue, clk_i, rst_ni, s_axis_tready != push_ready)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the text stream display filter, with a line-display predictor.
`timescale 1ns / 100ps

module tb_top;
  import tsdf_pkg::*;

  localparam int NDIG = NUMBER_DIGITS_DEF;
  localparam int MINW = MIN_FIELD_WIDTH_DEF;
  localparam logic [39:0] COUNT_CAP_BCD = 40'h2147483647;
  localparam int IDLE_LIMIT = 4000;
  localparam int MAX_PRINTS = 50;

  typedef struct packed {
    logic [7:0] ch;
    logic       fstart;
  } text_byte_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } shown_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = 8'd0;   // in_byte
  logic                s_axis_tuser = 1'b0;   // file_start
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;          // out_byte
  logic                m_axis_tlast;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [31:0]         pwdata = 32'd0;
  logic [31:0]         prdata;
  logic                pready;

  text_byte_t  text_feed_q[$];
  shown_byte_t shown_q[$];
  shown_byte_t want;

  cfg_t        opt = '0;
  logic [7:0]  prev_ch;
  logic [1:0]  blank_cnt;
  logic [3:0]  line_bcd [NDIG];

  int err_cnt = 0;
  int idle_cycles = 0;
  int gap_pct = 0;
  int ready_pct = 100;
  int burst_left = 0;
  int gap_left = 0;

  text_stream_display_filter_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_PRINTS) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  function automatic void clear_line_state();
    prev_ch = CH_NL;
    blank_cnt = 2'd0;
    for (int i = 0; i < NDIG; i++) line_bcd[i] = 4'd0;
  endfunction

  function automatic void bump_line_count();
    logic all_nine;
    logic at_max;
    logic [3:0] cap;
    all_nine = 1'b1;
    at_max = (NDIG >= 10);
    for (int i = 0; i < NDIG; i++) begin
      cap = (i < 10) ? COUNT_CAP_BCD[i*4 +: 4] : 4'd0;
      if (line_bcd[i] != BCD_NINE) all_nine = 1'b0;
      if (line_bcd[i] != cap) at_max = 1'b0;
    end
    if (all_nine || at_max) return;
    for (int i = 0; i < NDIG; i++) begin
      if (line_bcd[i] >= BCD_NINE) begin
        line_bcd[i] = 4'd0;
      end else begin
        line_bcd[i] = line_bcd[i] + 4'd1;
        return;
      end
    end
  endfunction

  function automatic void predict_display(input logic [7:0] raw, input logic fstart);
    logic [7:0] c;
    logic [7:0] seq[$];
    logic       num_line;
    int         sig;
    int         width;
    c = raw;
    if (fstart) clear_line_state();
    if (opt.squeeze_blank && c == CH_NL && prev_ch == CH_NL) begin
      if (blank_cnt < 2'd2) blank_cnt = blank_cnt + 2'd1;
      if (blank_cnt > 2'd1) return;
    end else begin
      blank_cnt = 2'd0;
    end
    num_line = opt.number_nonblank ? (c != CH_NL) : opt.number_all;
    if (prev_ch == CH_NL && num_line) begin
      bump_line_count();
      sig = 1;
      for (int i = 0; i < NDIG; i++) if (line_bcd[i] != 4'd0) sig = i + 1;
      width = (sig > MINW) ? sig : MINW;
      if (width > NDIG) width = NDIG;
      for (int i = width; i > sig; i--) seq.push_back(CH_SPACE);
      for (int i = sig - 1; i >= 0; i--) seq.push_back(CH_ZERO + line_bcd[i]);
      seq.push_back(CH_TAB);
    end
    if (opt.show_ends && c == CH_NL) seq.push_back(CH_DOLLAR);
    if (opt.show_tabs && c == CH_TAB) begin
      seq.push_back(CH_CARET);
      c = CH_I;
    end
    if (opt.show_nonprinting) begin
      if (c <= CTRL_LOW_END || (c >= CTRL_HIGH_BEG && c <= CTRL_HIGH_END)) begin
        seq.push_back(CH_CARET);
        c = c + CARET_SHIFT;
      end else if (c == CH_DEL) begin
        seq.push_back(CH_CARET);
        c = c - CARET_SHIFT;
      end
    end
    seq.push_back(c);
    prev_ch = c;
    foreach (seq[i]) shown_q.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_display(s_axis_tdata, s_axis_tuser);
        text_feed_q.delete(0);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (text_feed_q.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= text_feed_q[0].ch;
          s_axis_tuser <= text_feed_q[0].fstart;
          if (burst_left > 1) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 7) : 0;
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (shown_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat data=%02h last=%b",
                                  m_axis_tdata, m_axis_tlast));
      end else begin
        want = shown_q.pop_front();
        if (m_axis_tdata !== want.ch)
          report_mismatch($sformatf("out_byte %02h, expected %02h", m_axis_tdata, want.ch));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("last %b, expected %b", m_axis_tlast, want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns timeout with %0d beats outstanding", $time, shown_q.size());
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic val);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {31'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== {31'd0, val})
      report_mismatch($sformatf("register %0d reads %08h, expected %0d", idx, prdata, val));
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_options(input cfg_t v);
    write_reg(REG_SQUEEZE_BLANK, v.squeeze_blank);
    write_reg(REG_NUMBER_NONBLANK, v.number_nonblank);
    write_reg(REG_NUMBER_ALL, v.number_all);
    write_reg(REG_SHOW_ENDS, v.show_ends);
    write_reg(REG_SHOW_TABS, v.show_tabs);
    write_reg(REG_SHOW_NONPRINTING, v.show_nonprinting);
    opt = v;
  endtask

  task automatic push_byte(input logic [7:0] b, input logic fs);
    text_feed_q.push_back('{ch: b, fstart: fs});
  endtask

  task automatic feed_random_text(input int n_items);
    int cnt;
    int len;
    logic [7:0] b;
    logic fs;
    cnt = 0;
    while (cnt < n_items) begin
      len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
      fs = ($urandom_range(0, 19) == 0);
      for (int k = 0; k < len; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: b = 8'($urandom_range(32, 126));
          5:             b = CH_TAB;
          6:             b = 8'($urandom_range(0, 31));
          7:             b = CH_DEL;
          8:             b = 8'($urandom_range(128, 255));
          default:       b = 8'($urandom_range(0, 255));
        endcase
        push_byte(b, fs);
        fs = ($urandom_range(0, 59) == 0);
        cnt++;
      end
      push_byte(CH_NL, fs);
      cnt++;
    end
  endtask

  // Hold the sender until every queued byte has been taken and every expected beat is out.
  task automatic drain();
    while (text_feed_q.size() > 0 || s_axis_tvalid || shown_q.size() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  initial begin
    cfg_t v;
    clear_line_state();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    set_options('1);
    gap_pct = 30;
    ready_pct = 60;
    push_byte("a", 1'b1);
    push_byte(CH_TAB, 1'b0);
    push_byte(8'd0, 1'b0);
    push_byte(CH_DEL, 1'b0);
    push_byte(CTRL_HIGH_END, 1'b0);
    push_byte(CTRL_HIGH_BEG, 1'b0);
    push_byte(CTRL_LOW_END, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte(8'd255, 1'b0);
    push_byte(8'd128, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b1);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b0);
    drain();

    v = '0;
    v.squeeze_blank = 1'b1;
    v.number_all = 1'b1;
    set_options(v);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte(CH_NL, 1'b0);
    push_byte("x", 1'b0);
    push_byte(8'd12, 1'b0);
    push_byte(CH_TAB, 1'b0);
    push_byte(CH_NL, 1'b0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0:       v = '0;
        1:       v = '1;
        default: v = cfg_t'(6'($urandom_range(0, 63)));
      endcase
      set_options(v);
      gap_pct = (ph == 2) ? 0 : $urandom_range(0, 60);
      ready_pct = (ph == 2) ? 100 : $urandom_range(35, 100);
      feed_random_text(51);
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== text_stream_display_filter_core.f =====
+incdir+sv
sv/tsdf_pkg.sv
sv/tsdf_front.sv
sv/tsdf_fifo.sv
sv/tsdf_back.sv
sv/text_stream_display_filter_core.sv
tb/sv/tb_top.sv
